// File: rtl/dedq_pkg.sv
`default_nettype none
package dedq_pkg;

  // Ring geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_DISPLAY    = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic        [1:0]  status;
    logic               last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       walk_start;
    logic       walk_next;
    logic       load;
    logic       load_mem;
    logic [1:0] load_status;
    logic       load_walk_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic walk_last;
  } sts_t;

  // (base + off) modulo DEPTH, base < DEPTH, off <= DEPTH
  function automatic logic [ADDR_W-1:0] ring_add(logic [ADDR_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/dedq_ctrl.sv
`default_nettype none
module dedq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     in_mode_i,
  output logic           in_stall_o,
  input  dedq_pkg::sts_t sts_i,
  output dedq_pkg::cmd_t cmd_o
);
  import dedq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] pend_status_q, pend_status_d;
  logic       pend_mem_q, pend_mem_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d       = state_q;
    pend_status_d = pend_status_q;
    pend_mem_d    = pend_mem_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode_i)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              state_d    = ST_LOAD;
              pend_mem_d = 1'b0;
              if (sts_i.full) begin
                pend_status_d = STATUS_FULL;
              end else begin
                pend_status_d    = STATUS_OK;
                cmd_o.push_front = (in_mode_i == MODE_PUSH_FRONT);
                cmd_o.push_back  = (in_mode_i == MODE_PUSH_BACK);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              state_d = ST_LOAD;
              if (sts_i.empty) begin
                pend_status_d = STATUS_EMPTY;
                pend_mem_d    = 1'b0;
              end else begin
                pend_status_d   = STATUS_OK;
                pend_mem_d      = 1'b1;
                cmd_o.pop_front = (in_mode_i == MODE_POP_FRONT);
                cmd_o.pop_back  = (in_mode_i == MODE_POP_BACK);
              end
            end
            MODE_DISPLAY: begin
              if (sts_i.empty) begin
                state_d       = ST_LOAD;
                pend_status_d = STATUS_EMPTY;
                pend_mem_d    = 1'b0;
              end else begin
                state_d          = ST_WALK;
                cmd_o.walk_start = 1'b1;
              end
            end
            default: begin
              // unused code: dropped, no result
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load        = 1'b1;
          cmd_o.load_mem    = pend_mem_q;
          cmd_o.load_status = pend_status_q;
          state_d           = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.load           = 1'b1;
          cmd_o.load_mem       = 1'b1;
          cmd_o.load_status    = STATUS_OK;
          cmd_o.load_walk_last = 1'b1;
          if (sts_i.walk_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.walk_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pend_status_q <= STATUS_OK;
      pend_mem_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      pend_status_q <= pend_status_d;
      pend_mem_q    <= pend_mem_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dedq_datapath.sv
`default_nettype none
module dedq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] in_value_i,
  input  dedq_pkg::cmd_t     cmd_i,
  output dedq_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dedq_pkg::out_t     out_data_o
);
  import dedq_pkg::*;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_q;
  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              out_valid_q;
  out_t              out_data_q;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ADDR_W-1:0] front_dec;
  logic [CNT_W-1:0]  idx_inc;

  // Status toward the controller
  assign idx_inc         = CNT_W'(idx_q) + CNT_W'(1);
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.walk_last = (idx_inc == count_q);

  assign front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - ADDR_W'(1);

  // Pointer, count and memory port control
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = front_q;
    raddr   = front_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
      waddr   = front_dec;
      we      = 1'b1;
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.push_back) begin
      waddr   = ring_add(front_q, count_q);
      we      = 1'b1;
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop_front) begin
      raddr   = front_q;
      re      = 1'b1;
      front_d = ring_add(front_q, CNT_W'(1));
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.pop_back) begin
      raddr   = ring_add(front_q, count_q - CNT_W'(1));
      re      = 1'b1;
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.walk_start) begin
      raddr = front_q;
      re    = 1'b1;
      idx_d = '0;
    end
    if (cmd_i.walk_next) begin
      raddr = ring_add(front_q, idx_inc);
      re    = 1'b1;
      idx_d = idx_inc[ADDR_W-1:0];
    end
  end

  // Entry store, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_value_i;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q.out_value <= cmd_i.load_mem ? rd_q : 32'sd0;
      out_data_q.status    <= cmd_i.load_status;
      out_data_q.last      <= cmd_i.load_walk_last ? sts_o.walk_last : 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// File: rtl/double_ended_queue.sv
// A push or pop result is registered from the load state that follows the
// input transfer; that state waits while a stalled result holds the output.
// No new input is taken until the result of the last one is registered.
// Display of N entries: results follow one per cycle while the output is not
// stalled; the next input is taken after the last one is registered.
// Reset (async, active low) clears front pointer, count and output valid;
// the entry store is not cleared.
`default_nettype none
module double_ended_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dedq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dedq_pkg::out_t out_data_o
);
  import dedq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  dedq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring store, pointers and output register
  dedq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (in_data_i.item_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: rtl/dedq_checker.sv
`default_nettype none
module dedq_assert (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input dedq_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input dedq_pkg::out_t out_data_o
);
  import dedq_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A valid operation transfer is followed by a busy stall
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.mode == MODE_PUSH_FRONT || in_data_i.mode == MODE_PUSH_BACK ||
     in_data_i.mode == MODE_POP_FRONT || in_data_i.mode == MODE_POP_BACK ||
     in_data_i.mode == MODE_DISPLAY) |=> in_stall_o)
    else $error("operation transfer not followed by busy");

  // Status code in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status code");

  // Empty or full results carry zero value and close their run
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |->
      out_data_o.out_value == 32'sd0 && out_data_o.last)
    else $error("error result malformed");

endmodule

bind double_ended_queue dedq_assert u_dedq_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
